### hw/rtl/srdz_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package srdz_pkg;

    localparam int CFG_BITS = 16;

    typedef logic [CFG_BITS-1:0] cfg_word_t;

    typedef enum logic [0:0] {
        REG_DEAD_ZONE  = 1'b0,
        REG_FULL_SCALE = 1'b1
    } reg_index_t;

    localparam cfg_word_t DEAD_ZONE_RESET  = 16'd8000;
    localparam cfg_word_t FULL_SCALE_RESET = 16'd30000;

endpackage
`default_nettype wire

### hw/rtl/srdz_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module srdz_sqrt_cell #(
    parameter int SQW    = 36,
    parameter int STEP   = 0,
    parameter int SIDE_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [SQW-1:0]    in_rem,
    input  wire logic [SQW-1:0]    in_root,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [SQW-1:0]         out_rem,
    output logic [SQW-1:0]         out_root,
    output logic [SIDE_W-1:0]      out_side
);

    // Weight of the root digit settled by this cell.
    localparam logic [SQW-1:0] BIT_W = SQW'(1) << (SQW - 2 - 2 * STEP);

    logic              valid_reg;
    logic [SQW-1:0]    rem_reg;
    logic [SQW-1:0]    root_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [SQW-1:0]    trial;
    logic [SQW-1:0]    rem_next;
    logic [SQW-1:0]    root_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

    always_comb
    begin
        trial = in_root + BIT_W;
        if (in_rem >= trial)
        begin
            rem_next  = in_rem - trial;
            root_next = (in_root >> 1) + BIT_W;
        end
        else
        begin
            rem_next  = in_rem;
            root_next = in_root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= in_side;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/srdz_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module srdz_div_cell #(
    parameter int WW     = 50,
    parameter int DW     = 34,
    parameter int QW     = 16,
    parameter int SHIFT  = 0,
    parameter int SIDE_W = 3
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [WW-1:0]     in_rx,
    input  wire logic [WW-1:0]     in_ry,
    input  wire logic [QW-1:0]     in_qx,
    input  wire logic [QW-1:0]     in_qy,
    input  wire logic [DW-1:0]     in_d,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [WW-1:0]          out_rx,
    output logic [WW-1:0]          out_ry,
    output logic [QW-1:0]          out_qx,
    output logic [QW-1:0]          out_qy,
    output logic [DW-1:0]          out_d,
    output logic [SIDE_W-1:0]      out_side
);

    logic              valid_reg;
    logic [WW-1:0]     rx_reg;
    logic [WW-1:0]     ry_reg;
    logic [QW-1:0]     qx_reg;
    logic [QW-1:0]     qy_reg;
    logic [DW-1:0]     d_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [WW-1:0]     dsh;
    logic [WW-1:0]     rx_next;
    logic [WW-1:0]     ry_next;
    logic [QW-1:0]     qx_next;
    logic [QW-1:0]     qy_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_rx    = rx_reg;
    assign out_ry    = ry_reg;
    assign out_qx    = qx_reg;
    assign out_qy    = qy_reg;
    assign out_d     = d_reg;
    assign out_side  = side_reg;

    // Both components share the divisor, so each cell settles one quotient bit per lane.
    always_comb
    begin
        dsh     = WW'(in_d) << SHIFT;
        rx_next = in_rx;
        ry_next = in_ry;
        qx_next = in_qx;
        qy_next = in_qy;
        if (in_rx >= dsh)
        begin
            rx_next        = in_rx - dsh;
            qx_next[SHIFT] = 1'b1;
        end
        if (in_ry >= dsh)
        begin
            ry_next        = in_ry - dsh;
            qy_next[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            qx_reg   <= qx_next;
            qy_reg   <= qy_next;
            d_reg    <= in_d;
            side_reg <= in_side;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/stick_radial_dead_zone.sv
`timescale 1ns / 1ps
`default_nettype none
// Radial dead zone for an analog stick.
// Input words arrive on the s_ stream: tdata holds x_in then y_in, two's complement.
// Output words leave on the m_ stream: tdata holds x_out then y_out, Q1.15 direction
// scaled by how far the stick sits between the dead-zone and full-scale circles.
// dead_zone (address 0) and full_scale (address 4) are written over the APB port;
// change them only while no word is in flight.
// Throughput is one word per cycle while the receiver takes words. The stages, in
// order: stage 0 (magnitudes), stage 1 (squares), stage 2 (sum), one square-root
// cell per root bit, stage P (fraction), stage M (products), one divider cell per
// quotient bit, and the output register. Every stage carries its own valid flag
// and holds when the stage after it is full and cannot pass its word on, so a
// stalled receiver fills the row from the end and s_tready falls only once all
// stages hold words; empty stages keep accepting meanwhile.
// Reset empties the pipeline and loads dead_zone 8000 and full_scale 30000.
module stick_radial_dead_zone #(
    parameter int AXIS_BITS = 17,
    parameter int OUT_BITS  = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    s_tvalid,
    output logic                                         s_tready,
    // x_in, y_in
    input  wire logic [((2*AXIS_BITS+7)/8)*8-1:0]        s_tdata,
    output logic                                         m_tvalid,
    input  wire logic                                    m_tready,
    // x_out, y_out, zero fill
    output logic [((2*OUT_BITS+7)/8)*8-1:0]              m_tdata,
    input  wire logic                                    psel,
    input  wire logic                                    penable,
    input  wire logic                                    pwrite,
    input  wire logic [2:0]                              paddr,
    input  wire logic [31:0]                             pwdata,
    output logic [31:0]                                  prdata,
    output logic                                         pready
);
    import srdz_pkg::*;

    localparam int MW    = AXIS_BITS;
    localparam int SW    = 2 * MW + 1;
    localparam int RW    = (SW + 1) / 2;
    localparam int SQW   = 2 * RW;
    localparam int LW    = RW;
    localparam int CMPW  = (SW > 2 * CFG_BITS) ? SW : 2 * CFG_BITS;
    localparam int EW    = ((LW > CFG_BITS) ? LW : CFG_BITS) + 1;
    localparam int NXW   = MW + CFG_BITS;
    localparam int DW    = CFG_BITS + LW;
    localparam int RMW   = NXW + OUT_BITS - 1;
    localparam int WW    = ((RMW > DW + OUT_BITS) ? RMW : DW + OUT_BITS) + 1;
    localparam int SIDEW = 2 * MW + 3;
    localparam int OTW   = ((2 * OUT_BITS + 7) / 8) * 8;
    localparam logic [OUT_BITS-1:0] MAXV = {1'b0, {(OUT_BITS-1){1'b1}}};

    // Configuration registers.
    cfg_word_t dead_zone_reg;
    cfg_word_t full_scale_reg;
    logic [2*CFG_BITS-1:0] dz_sq_reg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg  <= DEAD_ZONE_RESET;
            full_scale_reg <= FULL_SCALE_RESET;
            dz_sq_reg      <= '0;
        end
        else
        begin
            dz_sq_reg <= (2*CFG_BITS)'(dead_zone_reg) * (2*CFG_BITS)'(dead_zone_reg);
            if (cfg_wr)
            begin
                case (reg_index_t'(paddr[2]))
                    REG_DEAD_ZONE:  dead_zone_reg  <= pwdata[CFG_BITS-1:0];
                    REG_FULL_SCALE: full_scale_reg <= pwdata[CFG_BITS-1:0];
                    default:        dead_zone_reg  <= dead_zone_reg;
                endcase
            end
        end
    end

    always_comb
    begin
        case (reg_index_t'(paddr[2]))
            REG_DEAD_ZONE:  prdata = 32'(dead_zone_reg);
            REG_FULL_SCALE: prdata = 32'(full_scale_reg);
            default:        prdata = '0;
        endcase
    end

    // Stage 0: magnitudes and signs.
    logic          v0_reg, v1_reg, v2_reg, vp_reg, vm_reg, vo_reg;
    logic          r0, r1, r2, rp, rm, ro;
    logic [MW-1:0] xin, yin;
    logic [MW-1:0] xm0_reg, ym0_reg;
    logic          xn0_reg, yn0_reg;

    assign xin = s_tdata[MW-1:0];
    assign yin = s_tdata[2*MW-1:MW];
    assign r0  = !v0_reg || r1;
    assign s_tready = r0;

    always_ff @(posedge clk)
    begin
        if (r0 && s_tvalid)
        begin
            xm0_reg <= xin[MW-1] ? (~xin + MW'(1)) : xin;
            ym0_reg <= yin[MW-1] ? (~yin + MW'(1)) : yin;
            xn0_reg <= xin[MW-1];
            yn0_reg <= yin[MW-1];
        end
    end

    // Stage 1: squares.
    logic [2*MW-1:0] xx1_reg, yy1_reg;
    logic [MW-1:0]   xm1_reg, ym1_reg;
    logic            xn1_reg, yn1_reg;

    assign r1 = !v1_reg || r2;

    always_ff @(posedge clk)
    begin
        if (r1 && v0_reg)
        begin
            xx1_reg <= (2*MW)'(xm0_reg) * (2*MW)'(xm0_reg);
            yy1_reg <= (2*MW)'(ym0_reg) * (2*MW)'(ym0_reg);
            xm1_reg <= xm0_reg;
            ym1_reg <= ym0_reg;
            xn1_reg <= xn0_reg;
            yn1_reg <= yn0_reg;
        end
    end

    // Stage 2: squared radius and dead-zone test.
    logic [SW-1:0]    s2_reg;
    logic [SIDEW-1:0] side2_reg;
    logic [SW-1:0]    s_sum;

    assign s_sum = SW'(xx1_reg) + SW'(yy1_reg);

    always_ff @(posedge clk)
    begin
        if (r2 && v1_reg)
        begin
            s2_reg    <= s_sum;
            side2_reg <= {CMPW'(s_sum) < CMPW'(dz_sq_reg), yn1_reg, xn1_reg, ym1_reg, xm1_reg};
        end
    end

    // Square-root cell row, one root bit per cell.
    logic             sq_v   [0:RW];
    logic             sq_r   [0:RW];
    logic [SQW-1:0]   sq_rem [0:RW];
    logic [SQW-1:0]   sq_root[0:RW];
    logic [SIDEW-1:0] sq_side[0:RW];

    assign sq_v[0]    = v2_reg;
    assign r2         = !v2_reg || sq_r[0];
    assign sq_rem[0]  = SQW'(s2_reg);
    assign sq_root[0] = '0;
    assign sq_side[0] = side2_reg;
    assign sq_r[RW]   = rp;

    for (genvar k = 0; k < RW; k++)
    begin : g_sqrt
        srdz_sqrt_cell #(.SQW(SQW), .STEP(k), .SIDE_W(SIDEW)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_v[k]),
            .in_ready  (sq_r[k]),
            .in_rem    (sq_rem[k]),
            .in_root   (sq_root[k]),
            .in_side   (sq_side[k]),
            .out_valid (sq_v[k+1]),
            .out_ready (sq_r[k+1]),
            .out_rem   (sq_rem[k+1]),
            .out_root  (sq_root[k+1]),
            .out_side  (sq_side[k+1])
        );
    end

    // Stage P: fraction numerator and denominator.
    logic [LW-1:0]       len;
    logic [SIDEW-1:0]    sidef;
    logic [EW-1:0]       diff;
    cfg_word_t           num_c, den_c;
    cfg_word_t           nump_reg, denp_reg;
    logic [LW-1:0]       lenp_reg;
    logic [MW-1:0]       xmp_reg, ymp_reg;
    logic                xnp_reg, ynp_reg, zp_reg;

    assign len   = sq_root[RW][LW-1:0];
    assign sidef = sq_side[RW];
    assign rp    = !vp_reg || rm;
    assign diff  = EW'(len) - EW'(dead_zone_reg);

    always_comb
    begin
        if (full_scale_reg > dead_zone_reg)
        begin
            den_c = full_scale_reg - dead_zone_reg;
            num_c = (diff > EW'(den_c)) ? den_c : diff[CFG_BITS-1:0];
        end
        else
        begin
            den_c = cfg_word_t'(1);
            num_c = cfg_word_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rp && sq_v[RW])
        begin
            nump_reg <= num_c;
            denp_reg <= den_c;
            lenp_reg <= len;
            xmp_reg  <= sidef[MW-1:0];
            ymp_reg  <= sidef[2*MW-1:MW];
            xnp_reg  <= sidef[2*MW];
            ynp_reg  <= sidef[2*MW+1];
            zp_reg   <= sidef[2*MW+2] || (len == '0);
        end
    end

    // Stage M: dividend and divisor products.
    logic [NXW-1:0] nxm_reg, nym_reg;
    logic [DW-1:0]  dm_reg;
    logic [2:0]     sidem_reg;
    logic           dv_r0;

    assign rm = !vm_reg || dv_r0;

    always_ff @(posedge clk)
    begin
        if (rm && vp_reg)
        begin
            nxm_reg   <= NXW'(xmp_reg) * NXW'(nump_reg);
            nym_reg   <= NXW'(ymp_reg) * NXW'(nump_reg);
            dm_reg    <= DW'(denp_reg) * DW'(lenp_reg);
            sidem_reg <= {zp_reg, ynp_reg, xnp_reg};
        end
    end

    // Divider cell row, quotient bits from the top down. The quotient never exceeds
    // one full unit because a component is never longer than the floor length.
    logic                dv_v   [0:OUT_BITS];
    logic                dv_r   [0:OUT_BITS];
    logic [WW-1:0]       dv_rx  [0:OUT_BITS];
    logic [WW-1:0]       dv_ry  [0:OUT_BITS];
    logic [OUT_BITS-1:0] dv_qx  [0:OUT_BITS];
    logic [OUT_BITS-1:0] dv_qy  [0:OUT_BITS];
    logic [DW-1:0]       dv_d   [0:OUT_BITS];
    logic [2:0]          dv_side[0:OUT_BITS];

    assign dv_v[0]    = vm_reg;
    assign dv_r0      = dv_r[0];
    assign dv_rx[0]   = WW'(nxm_reg) << (OUT_BITS - 1);
    assign dv_ry[0]   = WW'(nym_reg) << (OUT_BITS - 1);
    assign dv_qx[0]   = '0;
    assign dv_qy[0]   = '0;
    assign dv_d[0]    = dm_reg;
    assign dv_side[0] = sidem_reg;
    assign dv_r[OUT_BITS] = ro;

    for (genvar i = 0; i < OUT_BITS; i++)
    begin : g_div
        srdz_div_cell #(
            .WW(WW), .DW(DW), .QW(OUT_BITS), .SHIFT(OUT_BITS - 1 - i), .SIDE_W(3)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_v[i]),
            .in_ready  (dv_r[i]),
            .in_rx     (dv_rx[i]),
            .in_ry     (dv_ry[i]),
            .in_qx     (dv_qx[i]),
            .in_qy     (dv_qy[i]),
            .in_d      (dv_d[i]),
            .in_side   (dv_side[i]),
            .out_valid (dv_v[i+1]),
            .out_ready (dv_r[i+1]),
            .out_rx    (dv_rx[i+1]),
            .out_ry    (dv_ry[i+1]),
            .out_qx    (dv_qx[i+1]),
            .out_qy    (dv_qy[i+1]),
            .out_d     (dv_d[i+1]),
            .out_side  (dv_side[i+1])
        );
    end

    // Output register: clamp, sign, and dead-zone zeroing.
    logic [OUT_BITS-1:0] qx_c, qy_c, xo_c, yo_c;
    logic [OUT_BITS-1:0] xo_reg, yo_reg;
    logic [2:0]          sidef_d;

    assign sidef_d = dv_side[OUT_BITS];
    assign ro      = !vo_reg || m_tready;

    always_comb
    begin
        qx_c = (dv_qx[OUT_BITS] > MAXV) ? MAXV : dv_qx[OUT_BITS];
        qy_c = (dv_qy[OUT_BITS] > MAXV) ? MAXV : dv_qy[OUT_BITS];
        xo_c = sidef_d[0] ? (~qx_c + OUT_BITS'(1)) : qx_c;
        yo_c = sidef_d[1] ? (~qy_c + OUT_BITS'(1)) : qy_c;
        if (sidef_d[2])
        begin
            xo_c = '0;
            yo_c = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ro && dv_v[OUT_BITS])
        begin
            xo_reg <= xo_c;
            yo_reg <= yo_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vp_reg <= 1'b0;
            vm_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (r0) v0_reg <= s_tvalid;
            if (r1) v1_reg <= v0_reg;
            if (r2) v2_reg <= v1_reg;
            if (rp) vp_reg <= sq_v[RW];
            if (rm) vm_reg <= vp_reg;
            if (ro) vo_reg <= dv_v[OUT_BITS];
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = OTW'({yo_reg, xo_reg});

    // An empty output register means every stage can take a word.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output register");

    a_no_most_negative: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (xo_reg != {1'b1, {(OUT_BITS-1){1'b0}}}) &&
                     (yo_reg != {1'b1, {(OUT_BITS-1){1'b0}}}))
        else $error("output escaped symmetric saturation");

    a_full_scale_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr && paddr[2] |=> full_scale_reg == $past(pwdata[CFG_BITS-1:0]))
        else $error("full_scale write lost");

    a_dz_square: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $stable(dead_zone_reg) |=>
            dz_sq_reg == (2*CFG_BITS)'(dead_zone_reg) * (2*CFG_BITS)'(dead_zone_reg) ||
            !$stable(dead_zone_reg))
        else $error("dead-zone square out of date");

endmodule
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import srdz_pkg::*;

    localparam int AXIS_BITS = 17;
    localparam int OUT_BITS  = 16;
    localparam int IN_W  = ((2*AXIS_BITS+7)/8)*8;
    localparam int OUT_W = ((2*OUT_BITS+7)/8)*8;
    localparam int LATENCY = AXIS_BITS + OUT_BITS + 7;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [OUT_BITS-1:0] y;
        logic [OUT_BITS-1:0] x;
    } stick_out_t;

    typedef struct {
        logic [AXIS_BITS-1:0] x;
        logic [AXIS_BITS-1:0] y;
        bit                   typed;
        logic [OUT_BITS-1:0]  ex;
        logic [OUT_BITS-1:0]  ey;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    stick_radial_dead_zone dut (.*);

    always #5 clk = ~clk;

    cfg_word_t dz_q = DEAD_ZONE_RESET;
    cfg_word_t fs_q = FULL_SCALE_RESET;
    stick_out_t expected_words[$];
    int errors = 0;
    int idle_cycles = 0;
    bit sender_done = 0;
    bit random_stall = 1;

    function automatic logic [63:0] int_sqrt(logic [63:0] s);
        logic [63:0] root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0)
        begin
            if (s >= root + bitv)
            begin
                s -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic [OUT_BITS-1:0] scale_axis(logic [63:0] mag, bit neg,
            logic [63:0] num, logic [63:0] den, logic [63:0] len);
        logic [63:0] q;
        q = (mag * num * (64'd1 << (OUT_BITS-1))) / (den * len);
        if (q > (64'd1 << (OUT_BITS-1)) - 1) q = (64'd1 << (OUT_BITS-1)) - 1;
        if (neg) q = ~q + 1;
        return q[OUT_BITS-1:0];
    endfunction

    function automatic stick_out_t dead_zone_scale(logic [AXIS_BITS-1:0] x,
            logic [AXIS_BITS-1:0] y);
        stick_out_t r;
        logic [63:0] xm, ym, s, len, num, den;
        bit xn, yn;
        xn = x[AXIS_BITS-1];
        yn = y[AXIS_BITS-1];
        xm = xn ? 64'((~x + 1'b1) & {AXIS_BITS{1'b1}}) : 64'(x);
        ym = yn ? 64'((~y + 1'b1) & {AXIS_BITS{1'b1}}) : 64'(y);
        s = xm*xm + ym*ym;
        r = '0;
        if (s < 64'(dz_q) * 64'(dz_q)) return r;
        len = int_sqrt(s);
        if (len == 0) return r;
        if (fs_q > dz_q)
        begin
            den = 64'(fs_q) - 64'(dz_q);
            num = len - 64'(dz_q);
            if (num > den) num = den;
        end
        else
        begin
            num = 1;
            den = 1;
        end
        r.x = scale_axis(xm, xn, num, den, len);
        r.y = scale_axis(ym, yn, num, den, len);
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Receiver: random back-pressure; checks each word against the oldest expectation.
    always @(posedge clk)
    begin
        stick_out_t got, want;
        if (m_tvalid && m_tready)
        begin
            got = m_tdata[2*OUT_BITS-1:0];
            if (expected_words.size() == 0)
            begin
                $error("unexpected output word x=%0d y=%0d", $signed(got.x), $signed(got.y));
                errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (got.x !== want.x)
                begin
                    $error("x_out expected %0d actual %0d", $signed(want.x), $signed(got.x));
                    errors++;
                end
                if (got.y !== want.y)
                begin
                    $error("y_out expected %0d actual %0d", $signed(want.y), $signed(got.y));
                    errors++;
                end
            end
        end
    end

    int stall_left = 0;
    always @(negedge clk)
    begin
        if (!random_stall)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            stall_left = gap_len();
            m_tready <= (stall_left == 0);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles = 0;
        else if (++idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic reg_write(reg_index_t idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(idx) << 2;
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_DEAD_ZONE) dz_q = val[15:0];
        else fs_q = val[15:0];
    endtask

    task automatic send_word(logic [AXIS_BITS-1:0] x, logic [AXIS_BITS-1:0] y,
            bit typed, stick_out_t typed_out);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_tdata <= IN_W'({y, x});
        s_tvalid <= 1'b1;
        expected_words.push_back(typed ? typed_out : dead_zone_scale(x, y));
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (expected_words.size() != 0) @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    localparam logic [AXIS_BITS-1:0] AMAX = 17'sd32767;
    localparam logic [AXIS_BITS-1:0] AMIN = -17'sd32768;
    localparam logic [AXIS_BITS-1:0] APOS = 17'sd32768;
    localparam logic [AXIS_BITS-1:0] AMOST_NEG = 17'h10000;
    localparam logic [OUT_BITS-1:0] FULL_POS = 16'sd32767;
    localparam logic [OUT_BITS-1:0] FULL_NEG = -16'sd32767;

    stim_row_t directed[] = '{
        '{17'd0, 17'd0, 1, 16'd0, 16'd0},          // centered
        '{17'd100, -17'sd100, 1, 16'd0, 16'd0},    // inside dead zone
        '{17'd7999, 17'd0, 1, 16'd0, 16'd0},       // just inside
        '{17'd8000, 17'd0, 0, 0, 0},               // on the dead-zone circle
        '{17'd30000, 17'd0, 1, FULL_POS, 16'd0},   // full scale
        '{AMAX, 17'd0, 1, FULL_POS, 16'd0},
        '{AMIN, 17'd0, 1, FULL_NEG, 16'd0},
        '{17'd0, APOS, 1, 16'd0, FULL_POS},
        '{AMOST_NEG, AMOST_NEG, 0, 0, 0},          // out-of-range pattern
        '{17'hFFFF, 17'h0FFFF, 0, 0, 0},
        '{AMAX, AMAX, 0, 0, 0},
        '{AMIN, AMAX, 0, 0, 0},
        '{17'd15000, 17'd15000, 0, 0, 0},
        '{17'd20000, -17'sd3, 0, 0, 0},
        '{17'h1FFFF, 17'h1FFFF, 1, 16'd0, 16'd0}
    };

    task automatic random_phase(int n);
        logic [AXIS_BITS-1:0] x, y;
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 9);
            if (k == 0)
            begin
                x = 17'($urandom);
                y = 17'($urandom);
            end
            else if (k < 3)
            begin
                x = 17'($signed($urandom_range(0, 1200)) - 600);
                y = 17'($signed($urandom_range(0, 1200)) - 600);
            end
            else
            begin
                x = 17'($signed($urandom_range(0, 65536)) - 32768);
                y = 17'($signed($urandom_range(0, 65536)) - 32768);
            end
            send_word(x, y, 0, '0);
        end
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (directed[i])
            send_word(directed[i].x, directed[i].y, directed[i].typed,
                {directed[i].ey, directed[i].ex});
        drain();
        // Degenerate settings: zero dead zone, full scale not above dead zone.
        reg_write(REG_DEAD_ZONE, 32'd0);
        reg_write(REG_FULL_SCALE, 32'd0);
        send_word(17'd0, 17'd0, 1, '0);
        send_word(17'd1, 17'd1, 0, '0);
        random_phase(60);
        drain();
        reg_write(REG_DEAD_ZONE, 32'hFFFF);
        reg_write(REG_FULL_SCALE, 32'd46341);
        send_word(AMIN, AMIN, 0, '0);
        random_phase(40);
        drain();
        reg_write(REG_DEAD_ZONE, 32'd1);
        reg_write(REG_FULL_SCALE, 32'hFFFF);
        random_phase(100);
        // Receiver runs without stalls while the sender waits.
        random_stall = 0;
        drain();
        random_stall = 1;
        reg_write(REG_DEAD_ZONE, 32'd46341);
        reg_write(REG_FULL_SCALE, 32'd1);
        random_phase(50);
        drain();
        for (int p = 0; p < 5; p++)
        begin
            reg_write(REG_DEAD_ZONE, $urandom_range(0, 16'hFFFF) & (p[0] ? 32'h3FFF : 32'hFFFF));
            reg_write(REG_FULL_SCALE, $urandom_range(0, 16'hFFFF) & (p[1] ? 32'h7FFF : 32'hFFFF));
            random_phase(60);
            drain();
        end
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

### sim.f
hw/rtl/srdz_pkg.sv
hw/rtl/srdz_sqrt_cell.sv
hw/rtl/srdz_div_cell.sv
hw/rtl/stick_radial_dead_zone.sv
sim/tb_top.sv
